>>> rtl/spfp_pkg.sv
// ----------------------------------------------------------------------------
// spfp_pkg
// shared types, constants and helpers of the signal phase frame parser
// ----------------------------------------------------------------------------
package spfp_pkg;

    // frame layout
    localparam int FRAME_BYTES = 71;
    localparam int PHASE_COUNT = 4;
    localparam int PHASE_SLOTS = 4;
    localparam int POS_W       = 7;

    localparam logic [15:0] SYNC_WORD = 16'hFD43;
    localparam logic [7:0]  MARK_A    = 8'hAA;
    localparam logic [7:0]  MARK_B    = 8'hBB;
    localparam int          POS_MARK_A = 4;
    localparam int          POS_MARK_B = 5;
    localparam logic [1:0]  MARKS_OK  = 2'b11;

    localparam int STATE_BASE = 8;
    localparam int STATE_STEP = 4;
    localparam int COUNT_BASE = 28;
    localparam int COUNT_STEP = 8;

    // lamp code remap
    localparam logic [3:0] RAW_LAMP_FOUR    = 4'h4;
    localparam logic [3:0] MAPPED_LAMP_FOUR = 4'h3;

    // frame record queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [3:0] light_t;
    typedef logic [7:0] byte_t;

    typedef struct packed {
        light_t [PHASE_SLOTS-1:0] state;
        byte_t  [PHASE_SLOTS-1:0] count;
    } spfp_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } spfp_qstat_t;

    function automatic light_t light_map(input byte_t raw);
        light_t n;
        n = raw[3:0];
        if (n == RAW_LAMP_FOUR)
            return MAPPED_LAMP_FOUR;
        return n;
    endfunction

endpackage

>>> rtl/spfp_front.sv
// ----------------------------------------------------------------------------
// spfp_front
// sync hunt, byte positioning, marker check and phase capture
// ----------------------------------------------------------------------------
module spfp_front
    import spfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  byte_t     data_byte,
    input  logic      q_full,
    output logic      push,
    output spfp_rec_t rec
);

    logic [15:0]      shift_reg, shift_next;
    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       marker_reg, marker_next;

    logic [15:0]      shift_cat;
    logic [POS_W-1:0] pos_inc;
    logic             accept;
    logic             sync_hit;
    logic             store;
    logic             frame_end;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign shift_cat = {shift_reg[7:0], data_byte};
    assign sync_hit  = (shift_cat == SYNC_WORD);
    assign pos_inc   = pos_reg + POS_W'(1);
    assign store     = accept && in_frame_reg && !sync_hit;
    assign frame_end = store && (pos_inc == POS_W'(FRAME_BYTES));
    assign push      = frame_end && (marker_reg == MARKS_OK);

    always_comb
    begin
        shift_next    = shift_reg;
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        marker_next   = marker_reg;
        if (accept)
        begin
            shift_next = shift_cat;
            if (!in_frame_reg)
            begin
                if (sync_hit)
                begin
                    in_frame_next = 1'b1;
                    pos_next      = POS_W'(2);
                end
            end
            else if (sync_hit)
            begin
                // repeated sync restarts the frame
                pos_next = POS_W'(2);
            end
            else
            begin
                if (pos_reg == POS_W'(POS_MARK_A))
                    marker_next[0] = (data_byte == MARK_A);
                if (pos_reg == POS_W'(POS_MARK_B))
                    marker_next[1] = (data_byte == MARK_B);
                pos_next = pos_inc;
                if (frame_end)
                begin
                    shift_next    = '0;
                    in_frame_next = 1'b0;
                    pos_next      = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= '0;
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            marker_reg   <= '0;
        end
        else
        begin
            shift_reg    <= shift_next;
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            marker_reg   <= marker_next;
        end
    end

    // per-phase capture lanes
    for (genvar g = 0; g < PHASE_SLOTS; g++)
    begin : g_lane
        if (g < PHASE_COUNT)
        begin : g_used
            localparam logic [POS_W-1:0] ST_POS = POS_W'(STATE_BASE + STATE_STEP * g);
            localparam logic [POS_W-1:0] CT_POS = POS_W'(COUNT_BASE + COUNT_STEP * g);
            light_t st_reg;
            byte_t  ct_reg;
            always_ff @(posedge clk)
            begin
                if (store && pos_reg == ST_POS)
                    st_reg <= light_map(data_byte);
                if (store && pos_reg == CT_POS)
                    ct_reg <= data_byte;
            end
            assign rec.state[g] = st_reg;
            assign rec.count[g] = ct_reg;
        end
        else
        begin : g_unused
            assign rec.state[g] = '0;
            assign rec.count[g] = '0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> pos_reg == '0)
        else $error("position not cleared while hunting");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (pos_reg >= POS_W'(2) && pos_reg < POS_W'(FRAME_BYTES)))
        else $error("frame position out of range");

endmodule

>>> rtl/spfp_queue.sv
// ----------------------------------------------------------------------------
// spfp_queue
// short queue of completed frame records between front and back
// ----------------------------------------------------------------------------
module spfp_queue
    import spfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  spfp_rec_t   rec_in,
    input  logic        pop,
    output spfp_qstat_t stat,
    output spfp_rec_t   head
);

    spfp_rec_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= rec_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("push into full record queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("pop from empty record queue");

endmodule

>>> rtl/spfp_back.sv
// ----------------------------------------------------------------------------
// spfp_back
// walks the phases of a queued frame record into the output register
// ----------------------------------------------------------------------------
module spfp_back
    import spfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  spfp_qstat_t stat,
    input  spfp_rec_t   head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  phase_index,
    output light_t      light_state,
    output byte_t       time_left,
    output logic        last_phase
);

    localparam logic [1:0] LAST_PHASE = 2'(PHASE_COUNT - 1);

    logic       out_valid_reg, out_valid_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] idx_reg;
    light_t     light_reg;
    byte_t      time_reg;
    logic       last_reg;
    logic       load;

    assign load = !stat.empty && (!out_valid_reg || out_ready);
    assign pop  = load && (phase_reg == LAST_PHASE);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            phase_next     = (phase_reg == LAST_PHASE) ? 2'd0 : phase_reg + 2'd1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            idx_reg   <= phase_reg;
            light_reg <= head.state[phase_reg];
            time_reg  <= head.count[phase_reg];
            last_reg  <= (phase_reg == LAST_PHASE);
        end
    end

    assign out_valid   = out_valid_reg;
    assign phase_index = idx_reg;
    assign light_state = light_reg;
    assign time_left   = time_reg;
    assign last_phase  = last_reg;

endmodule

>>> rtl/signal_phase_frame_parser.sv
// ----------------------------------------------------------------------------
// signal_phase_frame_parser
// traffic-signal controller frame parser, four phase results per good frame
// ----------------------------------------------------------------------------
// One byte item is taken per cycle. The front end hunts for the sync word
// 0xFD43, counts the frame to 71 bytes, checks the 0xAA/0xBB markers and
// captures each phase's lamp nibble and countdown byte as it streams past.
// A frame that passes the check is copied as one record into a two-entry
// queue; the back end turns each record into four result items, one per
// cycle unless stalled, through a registered output stage. Input ready
// drops only while that queue is full, i.e. when the output side has been
// stalled for longer than about one frame; otherwise the input runs at one
// item per cycle. Results pass the queue, then the output register. Failed
// frames give no results. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module signal_phase_frame_parser
    import spfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // byte input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    // phase result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] phase_index,
    output logic [3:0] light_state,
    output logic [7:0] time_left,
    output logic       last_phase
);

    spfp_qstat_t q_stat;
    spfp_rec_t   front_rec;
    spfp_rec_t   q_head;
    logic        q_push;
    logic        q_pop;

    // sync hunt, position counting, marker check, capture
    spfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .q_full    (q_stat.full),
        .push      (q_push),
        .rec       (front_rec)
    );

    // decouples the byte stream from result backpressure
    spfp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .rec_in (front_rec),
        .pop    (q_pop),
        .stat   (q_stat),
        .head   (q_head)
    );

    // one phase result per cycle from the head record while out_ready is high
    spfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .stat        (q_stat),
        .head        (q_head),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .phase_index (phase_index),
        .light_state (light_state),
        .time_left   (time_left),
        .last_phase  (last_phase)
    );

endmodule
